// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/shb_pkg.sv -----
// Shared constants and codes of the spread histogram binner.
package shb_pkg;

    localparam int MASS_W   = 26;
    localparam int INTEN_W  = 32;
    localparam int RIDX_W   = 10;
    localparam int SUM_W    = 40;
    localparam int CENTRE_W = 16;
    localparam int SIZE_W   = 16;
    localparam int SPREAD_W = 4;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 5;
    // Signed bin number: centre plus or minus spread, with a sign bit.
    localparam int BIN_W      = MASS_W + 2;
    localparam int OFFSET_W   = SPREAD_W + 1;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NBR_SPAN = 1'b1;

    localparam logic [SIZE_W-1:0]   BIN_SIZE_RESET = 16'd2048;
    localparam logic [SPREAD_W-1:0] NBR_SPAN_RESET = 4'd1;

endpackage

// ----- hdl/shb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module shb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/shb_div.sv -----
// Restoring divider, one quotient bit per cycle: mass over bin width.
module shb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [shb_pkg::MASS_W-1:0]    dividend,
    input  logic [shb_pkg::SIZE_W-1:0]    divisor,
    output logic                          done,
    output logic [shb_pkg::MASS_W-1:0]    quotient
);
    import shb_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(MASS_W - 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MASS_W-1:0]     quo_reg, quo_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [SIZE_W-1:0]     dvs;
    logic [SIZE_W:0]       rem_sh;
    logic [SIZE_W+1:0]     diff;
    logic                  fits;

    // A zero width divides as one.
    assign dvs    = (divisor == '0) ? SIZE_W'(1) : divisor;
    assign rem_sh = {rem_reg, quo_reg[MASS_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
    assign fits   = !diff[SIZE_W+1];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[MASS_W-2:0], fits};
            rem_next = fits ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/spread_histogram_binner_top.sv -----
// Top level of the spread histogram binner: sequencer, bin store and result registers.
//
// Mass spectrum histogram with neighbor spread. Issue a command by raising
// start while busy is low; that edge accepts the transaction. Every command
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall it, so capture it then. After reset the block sweeps
// the bin store to zero with busy high; configuration writes are taken during
// that sweep and at any other idle time (cfg_ready is always high). Per
// command: clear sweeps the store; read fetches one bin. Add peak runs the
// restoring divider, one quotient bit per cycle, then walks the offsets from
// minus to plus the neighbor span; each bin inside the store costs one
// read-modify-write through the single store port, and each bin below zero
// or past the end is skipped without a write.
module spread_histogram_binner_top #(
    parameter int NUM_BINS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [shb_pkg::CMD_W-1:0]        command,
    input  logic [shb_pkg::MASS_W-1:0]       peak_mass,
    input  logic [shb_pkg::INTEN_W-1:0]      peak_intensity,
    input  logic [shb_pkg::RIDX_W-1:0]       read_index,
    output logic                             done,
    output logic [shb_pkg::SUM_W-1:0]        bin_value,
    output logic [shb_pkg::CENTRE_W-1:0]     centre_bin,
    output logic [shb_pkg::STATUS_W-1:0]     status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [shb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [shb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import shb_pkg::*;

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam logic [BIN_W-1:0] NUM_BINS_B = BIN_W'(NUM_BINS);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(NUM_BINS - 1);
    localparam logic [SUM_W-1:0] SUM_MAX    = '1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_DIV   = 6'b000100,
        S_SEL   = 6'b001000,
        S_WR    = 6'b010000,
        S_RDOUT = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   clr_report_reg, clr_report_next;
    logic [IDX_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic [INTEN_W-1:0]     inten_reg, inten_next;
    logic [MASS_W-1:0]      centre_reg, centre_next;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;
    logic                   drop_reg, drop_next;
    logic                   sat_reg, sat_next;
    logic [SIZE_W-1:0]      bin_size_reg, bin_size_next;
    logic [SPREAD_W-1:0]    nbr_span_reg, nbr_span_next;
    logic                   done_reg, done_next;
    logic [SUM_W-1:0]       bin_value_reg, bin_value_next;
    logic [CENTRE_W-1:0]    centre_bin_reg, centre_bin_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic                   accept;
    logic                   div_start;
    logic                   div_done;
    logic [MASS_W-1:0]      div_quo;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SUM_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SUM_W-1:0]       ram_rdata;

    logic [BIN_W-1:0]       ridx_ext;
    logic                   ridx_over;
    logic [BIN_W-1:0]       bin_calc;
    logic                   bin_neg;
    logic                   bin_over;
    logic signed [OFFSET_W-1:0] spread_s;
    logic                   last_off;
    logic [SUM_W:0]         sum_wide;
    logic                   drop_any;
    logic                   sat_any;
    logic [STATUS_W-1:0]    add_status;
    logic [CENTRE_W-1:0]    centre_sat;

    assign accept    = start && (state_reg == S_IDLE);
    assign div_start = accept && (command == CMD_ADD);

    // Read index against the store size; a larger store never overflows it.
    assign ridx_ext  = BIN_W'(read_index);
    assign ridx_over = (ridx_ext >= NUM_BINS_B);

    // Bin under the current offset, signed so that bins below zero show up.
    assign bin_calc = {2'b00, centre_reg} + {{(BIN_W-OFFSET_W){offset_reg[OFFSET_W-1]}},
                                             offset_reg};
    assign bin_neg  = bin_calc[BIN_W-1];
    assign bin_over = !bin_neg && (bin_calc >= NUM_BINS_B);
    assign spread_s = $signed({1'b0, nbr_span_reg});
    assign last_off = (offset_reg == spread_s);

    // Saturating add of the read-modify-write.
    assign sum_wide = {1'b0, ram_rdata} + {{(SUM_W+1-INTEN_W){1'b0}}, inten_reg};

    assign drop_any = drop_reg || ((state_reg == S_SEL) && bin_over);
    assign sat_any  = sat_reg || ((state_reg == S_WR) && sum_wide[SUM_W]);
    assign add_status = sat_any ? STATUS_SAT : (drop_any ? STATUS_DROP : STATUS_OK);
    assign centre_sat = (|centre_reg[MASS_W-1:CENTRE_W]) ? '1 : centre_reg[CENTRE_W-1:0];

    // Configuration writes; to be done only while idle, which the block itself does not enforce, so always ready.
    always_comb
    begin
        bin_size_next = bin_size_reg;
        nbr_span_next = nbr_span_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BIN_SIZE: bin_size_next = cfg_data;
                REG_NBR_SPAN: nbr_span_next = cfg_data[SPREAD_W-1:0];
                default:      bin_size_next = bin_size_reg;
            endcase
        end
    end

    // Store port selection: the sweep and the add write, idle and select read.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_raddr = addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = ridx_ext[IDX_W-1:0];
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            S_SEL:
            begin
                ram_raddr = bin_calc[IDX_W-1:0];
            end
            S_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_report_next = clr_report_reg;
        clr_addr_next   = clr_addr_reg;
        addr_next       = addr_reg;
        inten_next      = inten_reg;
        centre_next     = centre_reg;
        offset_next     = offset_reg;
        drop_next       = drop_reg;
        sat_next        = sat_reg;
        done_next       = 1'b0;
        bin_value_next  = bin_value_reg;
        centre_bin_next = centre_bin_reg;
        status_next     = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        CMD_ADD:
                        begin
                            inten_next = peak_intensity;
                            drop_next  = 1'b0;
                            sat_next   = 1'b0;
                            state_next = S_DIV;
                        end
                        CMD_READ:
                        begin
                            if (ridx_over)
                            begin
                                done_next       = 1'b1;
                                bin_value_next  = '0;
                                centre_bin_next = '0;
                                status_next     = STATUS_DROP;
                            end
                            else
                            begin
                                state_next = S_RDOUT;
                            end
                        end
                        default:
                        begin
                            // Unused command: answer with all zeros.
                            done_next       = 1'b1;
                            bin_value_next  = '0;
                            centre_bin_next = '0;
                            status_next     = STATUS_OK;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_LAST)
                begin
                    state_next      = S_IDLE;
                    clr_report_next = 1'b0;
                    // The sweep after reset gives no result.
                    done_next       = clr_report_reg;
                    bin_value_next  = '0;
                    centre_bin_next = '0;
                    status_next     = STATUS_OK;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    centre_next = div_quo;
                    offset_next = -spread_s;
                    state_next  = S_SEL;
                end
            end
            S_SEL:
            begin
                drop_next = drop_any;
                if (bin_neg || bin_over)
                begin
                    // Skip bins below zero silently; drop those past the end.
                    if (last_off)
                    begin
                        state_next      = S_IDLE;
                        done_next       = 1'b1;
                        bin_value_next  = '0;
                        centre_bin_next = centre_sat;
                        status_next     = add_status;
                    end
                    else
                    begin
                        offset_next = offset_reg + OFFSET_W'(1);
                    end
                end
                else
                begin
                    addr_next  = bin_calc[IDX_W-1:0];
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                sat_next = sat_any;
                if (last_off)
                begin
                    state_next      = S_IDLE;
                    done_next       = 1'b1;
                    bin_value_next  = '0;
                    centre_bin_next = centre_sat;
                    status_next     = add_status;
                end
                else
                begin
                    offset_next = offset_reg + OFFSET_W'(1);
                    state_next  = S_SEL;
                end
            end
            S_RDOUT:
            begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                bin_value_next  = ram_rdata;
                centre_bin_next = '0;
                status_next     = STATUS_OK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset starts a silent clearing sweep of the store.
            state_reg      <= S_CLEAR;
            clr_report_reg <= 1'b0;
            clr_addr_reg   <= '0;
            done_reg       <= 1'b0;
            bin_size_reg   <= BIN_SIZE_RESET;
            nbr_span_reg   <= NBR_SPAN_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_report_reg <= clr_report_next;
            clr_addr_reg   <= clr_addr_next;
            done_reg       <= done_next;
            bin_size_reg   <= bin_size_next;
            nbr_span_reg   <= nbr_span_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        inten_reg      <= inten_next;
        centre_reg     <= centre_next;
        offset_reg     <= offset_next;
        drop_reg       <= drop_next;
        sat_reg        <= sat_next;
        bin_value_reg  <= bin_value_next;
        centre_bin_reg <= centre_bin_next;
        status_reg     <= status_next;
    end

    shb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (peak_mass),
        .divisor  (bin_size_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    shb_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign bin_value  = bin_value_reg;
    assign centre_bin = centre_bin_reg;
    assign status     = status_reg;

endmodule

// ----- hdl/shb_checker.sv -----
// Port-level checker of the spread histogram binner, bound to the top level.
`include "assert_macros.svh"

module shb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [shb_pkg::CMD_W-1:0]        command,
    input logic                             done,
    input logic [shb_pkg::SUM_W-1:0]        bin_value,
    input logic [shb_pkg::CENTRE_W-1:0]     centre_bin
);
    import shb_pkg::*;

    logic [CMD_W-1:0] last_cmd_reg, last_cmd_next;

    // Remember the command of the transaction in flight.
    assign last_cmd_next = (start && !busy) ? command : last_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cmd_reg <= CMD_CLEAR;
        end
        else
        begin
            last_cmd_reg <= last_cmd_next;
        end
    end

    // An accepted command either finishes at once or holds the block busy.
    `SHB_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done)
    // A result only shows once the sequencer has returned to idle.
    `SHB_ASSERT_IMP(a_done_idle, done, !busy)
    // Only an add reports a centre bin.
    `SHB_ASSERT_IMP(a_centre_add, done && (last_cmd_reg != CMD_ADD), centre_bin == '0)
    // Only a read reports a bin sum.
    `SHB_ASSERT_IMP(a_value_read, done && (last_cmd_reg != CMD_READ), bin_value == '0)

endmodule

bind spread_histogram_binner_top shb_checker u_shb_checker (.*);
